FILE: hdl/bpms_pkg.sv
package bpms_pkg;

  localparam int unsigned XLEN = 64;
  localparam int unsigned HALF = 32;
  localparam int unsigned IDXW = $clog2(XLEN);

  typedef enum logic [1:0] {
    OP_PDEP = 2'd0,
    OP_MULX = 2'd1,
    OP_SHRX = 2'd2
  } op_t;

  typedef struct packed {
    logic vld;
    op_t  op;
    logic wide;
  } ctrl_t;

endpackage

FILE: hdl/bmi2_pdep_mulx_shrx_unit_top.sv
// BMI2 execution unit for PDEP, MULX and SHRX without flags. It takes one
// instruction in every cycle, so busy is always low, and each result appears
// on the out_ ports for one cycle with out_valid high. On its way it passes
// the input register, the 32 by 32 bit partial products of MULX and their
// combining add, with the PDEP index computation and bit selection placed in
// the same two stages. Results are never held back: the receiver must take
// each one in the cycle it appears.
module bmi2_pdep_mulx_shrx_unit_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                in_operation,
  input  logic                      in_wide,
  input  logic [bpms_pkg::XLEN-1:0] in_operand_e,
  input  logic [bpms_pkg::XLEN-1:0] in_operand_v,
  input  logic [bpms_pkg::XLEN-1:0] in_operand_rdx,
  output logic                      out_valid,
  output logic [bpms_pkg::XLEN-1:0] out_main_result,
  output logic [bpms_pkg::XLEN-1:0] out_low_result,
  output logic                      out_low_valid
);
  import bpms_pkg::*;

  ctrl_t           ctrl0_r, ctrl1_r;
  logic [XLEN-1:0] e0_r, v0_r, rdx0_r;
  logic [XLEN-1:0] shr_nxt, shr1_r;
  logic [XLEN-1:0] dep_mask;
  logic [XLEN-1:0] mul_hi, mul_lo, dep_result;
  logic [XLEN-1:0] main_nxt, low_nxt;
  logic            low_vld_nxt;
  logic            out_valid_r, out_low_valid_r;
  logic [XLEN-1:0] out_main_r, out_low_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl0_r.vld <= 1'b0;
      ctrl1_r.vld <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ctrl0_r.vld <= start && !busy;
      ctrl1_r.vld <= ctrl0_r.vld;
      out_valid_r <= ctrl1_r.vld;
    end
    ctrl0_r.op   <= op_t'(in_operation);
    ctrl0_r.wide <= in_wide;
    e0_r         <= in_operand_e;
    v0_r         <= in_operand_v;
    rdx0_r       <= in_operand_rdx;
    ctrl1_r.op   <= ctrl0_r.op;
    ctrl1_r.wide <= ctrl0_r.wide;
    shr1_r       <= shr_nxt;
  end

  assign shr_nxt  = ctrl0_r.wide ? (e0_r >> v0_r[IDXW-1:0])
                  : {{HALF{1'b0}}, e0_r[HALF-1:0] >> v0_r[IDXW-2:0]};
  assign dep_mask = ctrl0_r.wide ? e0_r : {{HALF{1'b0}}, e0_r[HALF-1:0]};

  bpms_mul u_mul (
    .clk      (clk),
    .mul_wide (ctrl0_r.wide),
    .mul_a    (rdx0_r),
    .mul_b    (e0_r),
    .mul_hi   (mul_hi),
    .mul_lo   (mul_lo)
  );

  bpms_pdep u_pdep (
    .clk        (clk),
    .dep_mask   (dep_mask),
    .dep_src    (v0_r),
    .dep_result (dep_result)
  );

  always_comb begin
    main_nxt    = '0;
    low_nxt     = '0;
    low_vld_nxt = 1'b0;
    unique case (ctrl1_r.op)
      OP_PDEP: main_nxt = dep_result;
      OP_MULX: begin
        main_nxt    = mul_hi;
        low_nxt     = mul_lo;
        low_vld_nxt = 1'b1;
      end
      OP_SHRX: main_nxt = shr1_r;
      default: begin
        main_nxt    = '0;
        low_nxt     = '0;
        low_vld_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_low_valid_r <= 1'b0;
    end else begin
      out_low_valid_r <= ctrl1_r.vld && low_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_main_r <= main_nxt;
    out_low_r  <= low_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_main_result = out_main_r;
  assign out_low_result  = out_low_r;
  assign out_low_valid   = out_low_valid_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3)) |->
      (out_valid == $past(start && !busy, 3)))
    else $error("Result strobe does not follow its transfer by three cycles.");

  a_low_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_low_valid |-> out_valid)
    else $error("Low result flagged without a result strobe.");

  a_low_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_low_valid) |-> (out_low_result == '0))
    else $error("Low result is not zero for an operation without a low half.");

  a_mulx_low: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl1_r.vld && ctrl1_r.op == OP_MULX) |=> out_low_valid)
    else $error("MULX result lost its low half flag.");

endmodule

FILE: hdl/bpms_mul.sv
module bpms_mul (
  input  logic                      clk,
  input  logic                      mul_wide,
  input  logic [bpms_pkg::XLEN-1:0] mul_a,
  input  logic [bpms_pkg::XLEN-1:0] mul_b,
  output logic [bpms_pkg::XLEN-1:0] mul_hi,
  output logic [bpms_pkg::XLEN-1:0] mul_lo
);
  import bpms_pkg::*;

  logic [HALF-1:0] a_lo, a_hi, b_lo, b_hi;
  logic [XLEN-1:0] ll_nxt, lh_nxt, hl_nxt, hh_nxt;
  logic [XLEN-1:0] ll_r, lh_r, hl_r, hh_r;
  logic            wide_r;
  logic [HALF+1:0] mid;
  logic [XLEN-1:0] hi64, lo64;

  assign a_lo = mul_a[HALF-1:0];
  assign a_hi = mul_a[XLEN-1:HALF];
  assign b_lo = mul_b[HALF-1:0];
  assign b_hi = mul_b[XLEN-1:HALF];

  assign ll_nxt = {{HALF{1'b0}}, a_lo} * {{HALF{1'b0}}, b_lo};
  assign lh_nxt = {{HALF{1'b0}}, a_lo} * {{HALF{1'b0}}, b_hi};
  assign hl_nxt = {{HALF{1'b0}}, a_hi} * {{HALF{1'b0}}, b_lo};
  assign hh_nxt = {{HALF{1'b0}}, a_hi} * {{HALF{1'b0}}, b_hi};

  always_ff @(posedge clk) begin
    ll_r   <= ll_nxt;
    lh_r   <= lh_nxt;
    hl_r   <= hl_nxt;
    hh_r   <= hh_nxt;
    wide_r <= mul_wide;
  end

  assign mid  = {2'b00, ll_r[XLEN-1:HALF]} + {2'b00, lh_r[HALF-1:0]}
              + {2'b00, hl_r[HALF-1:0]};
  assign lo64 = {mid[HALF-1:0], ll_r[HALF-1:0]};
  assign hi64 = hh_r + {{HALF{1'b0}}, lh_r[XLEN-1:HALF]}
              + {{HALF{1'b0}}, hl_r[XLEN-1:HALF]}
              + {{(XLEN-2){1'b0}}, mid[HALF+1:HALF]};

  assign mul_hi = wide_r ? hi64 : {{HALF{1'b0}}, ll_r[XLEN-1:HALF]};
  assign mul_lo = wide_r ? lo64 : {{HALF{1'b0}}, ll_r[HALF-1:0]};

endmodule

FILE: hdl/bpms_pdep.sv
module bpms_pdep (
  input  logic                      clk,
  input  logic [bpms_pkg::XLEN-1:0] dep_mask,
  input  logic [bpms_pkg::XLEN-1:0] dep_src,
  output logic [bpms_pkg::XLEN-1:0] dep_result
);
  import bpms_pkg::*;

  logic [IDXW-1:0] idx_nxt [XLEN];
  logic [IDXW-1:0] idx_r   [XLEN];
  logic [XLEN-1:0] mask_r;
  logic [XLEN-1:0] src_r;

  // Each set mask bit takes the source bit whose index is the number of set mask bits below it.
  always_comb begin
    for (int pos = 0; pos < XLEN; pos++) begin
      idx_nxt[pos] = IDXW'($countones(dep_mask &
                     (({{(XLEN-1){1'b0}}, 1'b1} << pos) - {{(XLEN-1){1'b0}}, 1'b1})));
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    mask_r <= dep_mask;
    src_r  <= dep_src;
  end

  always_comb begin
    for (int pos = 0; pos < XLEN; pos++) begin
      dep_result[pos] = mask_r[pos] & src_r[idx_r[pos]];
    end
  end

endmodule

FILE: tb/sv/bpms_result_checker.sv
`timescale 1ns / 1ps

module bpms_result_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      busy,
  input  logic [1:0]                in_operation,
  input  logic                      in_wide,
  input  logic [bpms_pkg::XLEN-1:0] in_operand_e,
  input  logic [bpms_pkg::XLEN-1:0] in_operand_v,
  input  logic [bpms_pkg::XLEN-1:0] in_operand_rdx,
  input  logic                      out_valid,
  input  logic [bpms_pkg::XLEN-1:0] out_main_result,
  input  logic [bpms_pkg::XLEN-1:0] out_low_result,
  input  logic                      out_low_valid,
  output int                        fail_count,
  output int                        compared_count,
  output int                        pending_count
);
  import bpms_pkg::*;

  typedef struct packed {
    logic [XLEN-1:0] main_result;
    logic [XLEN-1:0] low_result;
    logic            low_valid;
  } writeback_t;

  writeback_t expected_writebacks[$];

  function automatic logic [XLEN-1:0] deposit_bits(input logic [XLEN-1:0] src,
                                                   input logic [XLEN-1:0] mask,
                                                   input int width);
    logic [XLEN-1:0] res;
    int next_src;
    res = '0;
    next_src = 0;
    for (int pos = 0; pos < width; pos++) begin
      if (mask[pos]) begin
        res[pos] = src[next_src];
        next_src++;
      end
    end
    return res;
  endfunction

  function automatic writeback_t execute_bmi2(input logic [1:0] op, input logic wide,
                                              input logic [XLEN-1:0] e,
                                              input logic [XLEN-1:0] v,
                                              input logic [XLEN-1:0] rdx);
    writeback_t wb;
    logic [2*XLEN-1:0] prod_wide;
    logic [XLEN-1:0] prod_half;
    wb = '0;
    case (op)
      OP_PDEP: begin
        if (wide) begin
          wb.main_result = deposit_bits(v, e, XLEN);
        end else begin
          wb.main_result = deposit_bits({{HALF{1'b0}}, v[HALF-1:0]},
                                        {{HALF{1'b0}}, e[HALF-1:0]}, HALF);
        end
      end
      OP_MULX: begin
        if (wide) begin
          prod_wide = {{XLEN{1'b0}}, rdx} * {{XLEN{1'b0}}, e};
          wb.main_result = prod_wide[2*XLEN-1:XLEN];
          wb.low_result = prod_wide[XLEN-1:0];
        end else begin
          prod_half = {{HALF{1'b0}}, rdx[HALF-1:0]} * {{HALF{1'b0}}, e[HALF-1:0]};
          wb.main_result = {{HALF{1'b0}}, prod_half[XLEN-1:HALF]};
          wb.low_result = {{HALF{1'b0}}, prod_half[HALF-1:0]};
        end
        wb.low_valid = 1'b1;
      end
      OP_SHRX: begin
        if (wide) begin
          wb.main_result = e >> v[IDXW-1:0];
        end else begin
          wb.main_result = {{HALF{1'b0}}, e[HALF-1:0]} >> v[IDXW-2:0];
        end
      end
      default: begin
      end
    endcase
    return wb;
  endfunction

  always @(posedge clk) begin
    writeback_t want;
    if (!rst_n) begin
      expected_writebacks.delete();
    end else begin
      if (start && !busy) begin
        expected_writebacks.push_back(execute_bmi2(in_operation, in_wide, in_operand_e,
                                                   in_operand_v, in_operand_rdx));
      end
      if (out_valid) begin
        if (expected_writebacks.size() == 0) begin
          $error("Result transfer arrived with no instruction outstanding.");
          fail_count++;
        end else begin
          want = expected_writebacks.pop_front();
          compared_count++;
          if (out_main_result !== want.main_result) begin
            $error("main_result: expected %h, got %h", want.main_result, out_main_result);
            fail_count++;
          end
          if (out_low_result !== want.low_result) begin
            $error("low_result: expected %h, got %h", want.low_result, out_low_result);
            fail_count++;
          end
          if (out_low_valid !== want.low_valid) begin
            $error("low_valid: expected %b, got %b", want.low_valid, out_low_valid);
            fail_count++;
          end
        end
      end
    end
    pending_count = expected_writebacks.size();
  end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import bpms_pkg::*;

  localparam logic [1:0] OP_NOP = 2'd3;
  localparam int WATCHDOG_LIMIT = 500;
  localparam int RANDOM_ITEMS = 550;
  localparam logic [XLEN-1:0] ALL_ONES = {XLEN{1'b1}};

  logic            clk;
  logic            rst_n;
  logic            start;
  logic            busy;
  logic [1:0]      in_operation;
  logic            in_wide;
  logic [XLEN-1:0] in_operand_e;
  logic [XLEN-1:0] in_operand_v;
  logic [XLEN-1:0] in_operand_rdx;
  logic            out_valid;
  logic [XLEN-1:0] out_main_result;
  logic [XLEN-1:0] out_low_result;
  logic            out_low_valid;

  int fail_count;
  int compared_count;
  int pending_count;
  int idle_cycles;
  int op_count[4];

  bmi2_pdep_mulx_shrx_unit_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_operation   (in_operation),
    .in_wide        (in_wide),
    .in_operand_e   (in_operand_e),
    .in_operand_v   (in_operand_v),
    .in_operand_rdx (in_operand_rdx),
    .out_valid      (out_valid),
    .out_main_result(out_main_result),
    .out_low_result (out_low_result),
    .out_low_valid  (out_low_valid)
  );

  bpms_result_checker result_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_operation   (in_operation),
    .in_wide        (in_wide),
    .in_operand_e   (in_operand_e),
    .in_operand_v   (in_operand_v),
    .in_operand_rdx (in_operand_rdx),
    .out_valid      (out_valid),
    .out_main_result(out_main_result),
    .out_low_result (out_low_result),
    .out_low_valid  (out_low_valid),
    .fail_count     (fail_count),
    .compared_count (compared_count),
    .pending_count  (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // A run is declared hung when no transfer happens on either side for too long.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid === 1'b1) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("bmi2_pdep_mulx_shrx_unit_top: mismatch");
        $finish;
      end
    end
  end

  task automatic issue(input logic [1:0] op, input logic wide, input logic [XLEN-1:0] e,
                       input logic [XLEN-1:0] v, input logic [XLEN-1:0] rdx, input int gap);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start          <= 1'b1;
    in_operation   <= op;
    in_wide        <= wide;
    in_operand_e   <= e;
    in_operand_v   <= v;
    in_operand_rdx <= rdx;
    do @(posedge clk); while (busy);
    op_count[op]++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  function automatic logic [XLEN-1:0] pick_operand();
    logic [XLEN-1:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: r = r & {$urandom, $urandom} & {$urandom, $urandom};
      1: r = r | {$urandom, $urandom} | {$urandom, $urandom};
      2: r = XLEN'($urandom_range(0, 70));
      3: r = XLEN'(1) << $urandom_range(0, XLEN - 1);
      4: r = ALL_ONES >> $urandom_range(0, XLEN - 1);
      5: r = ($urandom_range(0, 1) == 0) ? '0 : ALL_ONES;
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic logic [1:0] pick_operation();
    int pick;
    pick = $urandom_range(0, 15);
    if (pick < 5) return OP_PDEP;
    if (pick < 10) return OP_MULX;
    if (pick < 15) return OP_SHRX;
    return OP_NOP;
  endfunction

  initial begin
    int pause_at;
    int max_gap;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_operation   = OP_PDEP;
    in_wide        = 1'b0;
    in_operand_e   = '0;
    in_operand_v   = '0;
    in_operand_rdx = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    issue(OP_PDEP, 1'b1, ALL_ONES, ALL_ONES, ALL_ONES, 0);
    issue(OP_PDEP, 1'b1, '0, ALL_ONES, '0, 0);
    issue(OP_PDEP, 1'b1, ALL_ONES, 64'h0123_4567_89ab_cdef, '0, 1);
    issue(OP_PDEP, 1'b1, 64'h8000_0000_0000_0001, 64'h3, ALL_ONES, 0);
    issue(OP_PDEP, 1'b1, 64'haaaa_aaaa_aaaa_aaaa, 64'hffff_ffff, '0, 2);
    issue(OP_PDEP, 1'b0, 64'hffff_ffff_8000_0001, 64'hffff_ffff_0000_0003, '0, 0);
    issue(OP_PDEP, 1'b0, ALL_ONES, ALL_ONES, ALL_ONES, 0);
    issue(OP_MULX, 1'b1, ALL_ONES, ALL_ONES, ALL_ONES, 0);
    issue(OP_MULX, 1'b1, '0, ALL_ONES, ALL_ONES, 3);
    issue(OP_MULX, 1'b1, 64'h1, '0, ALL_ONES, 0);
    issue(OP_MULX, 1'b1, 64'h8000_0000_0000_0000, ALL_ONES, 64'h2, 0);
    issue(OP_MULX, 1'b0, ALL_ONES, ALL_ONES, ALL_ONES, 0);
    issue(OP_MULX, 1'b0, 64'hdead_beef_8000_0000, '0, 64'h1234_5678_0000_0002, 1);
    issue(OP_SHRX, 1'b1, ALL_ONES, '0, ALL_ONES, 0);
    issue(OP_SHRX, 1'b1, ALL_ONES, 64'd63, '0, 0);
    issue(OP_SHRX, 1'b1, ALL_ONES, 64'd64, '0, 0);
    issue(OP_SHRX, 1'b1, 64'h8000_0000_0000_0000, ALL_ONES, '0, 2);
    issue(OP_SHRX, 1'b0, ALL_ONES, 64'd31, '0, 0);
    issue(OP_SHRX, 1'b0, ALL_ONES, 64'd32, '0, 0);
    issue(OP_SHRX, 1'b0, 64'hffff_ffff_8000_0000, 64'h3f, ALL_ONES, 0);
    issue(OP_NOP, 1'b1, ALL_ONES, ALL_ONES, ALL_ONES, 0);
    issue(OP_NOP, 1'b0, ALL_ONES, ALL_ONES, ALL_ONES, 1);
    drain_results();

    pause_at = $urandom_range(50, RANDOM_ITEMS - 50);
    max_gap = 18;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) begin
        max_gap = ($urandom_range(0, 2) == 0) ? 0 : 18;
      end
      if (n == pause_at) begin
        drain_results();
      end
      issue(pick_operation(), 1'($urandom_range(0, 1)), pick_operand(), pick_operand(),
            pick_operand(), $urandom_range(0, max_gap));
    end
    drain_results();
    repeat (10) @(posedge clk);

    $display("Covered %0d transfers (%0d PDEP, %0d MULX, %0d SHRX, %0d unused code),",
             op_count[OP_PDEP] + op_count[OP_MULX] + op_count[OP_SHRX] + op_count[OP_NOP],
             op_count[OP_PDEP], op_count[OP_MULX], op_count[OP_SHRX], op_count[OP_NOP]);
    $display("both operand sizes, random gaps and back-to-back bursts; %0d results compared.",
             compared_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("bmi2_pdep_mulx_shrx_unit_top: match");
    end else begin
      $display("bmi2_pdep_mulx_shrx_unit_top: mismatch");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/bpms_pkg.sv
hdl/bpms_mul.sv
hdl/bpms_pdep.sv
hdl/bmi2_pdep_mulx_shrx_unit_top.sv
tb/sv/bpms_result_checker.sv
tb/sv/tb.sv
